[src/mgfs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register indexes, reset values and the band decode
// for the motion-gated fan stepper controller. No dependencies.
package mgfs_pkg;

	// Configuration register file as seen by the tick logic
	typedef struct packed {
		logic [7:0]  slow_th;
		logic [7:0]  med_th;
		logic [7:0]  fast_th;
		logic [15:0] hold_ticks;
		logic [7:0]  period;
		logic [7:0]  wait_slow;
		logic [7:0]  wait_med;
		logic [7:0]  wait_fast;
	} cfg_t;

	// Temperature band membership, one bit per band
	typedef struct packed {
		logic slow;
		logic med;
		logic fast;
	} band_t;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_TH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MED_TH     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_TH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_SLOW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_MED   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_FAST  = 3'd7;

	// Register reset values
	localparam logic [7:0]  RST_SLOW_TH    = 8'd140;
	localparam logic [7:0]  RST_MED_TH     = 8'd170;
	localparam logic [7:0]  RST_FAST_TH    = 8'd176;
	localparam logic [15:0] RST_HOLD_TICKS = 16'd4000;
	localparam logic [7:0]  RST_PERIOD     = 8'd150;
	localparam logic [7:0]  RST_WAIT_SLOW  = 8'd6;
	localparam logic [7:0]  RST_WAIT_MED   = 8'd4;
	localparam logic [7:0]  RST_WAIT_FAST  = 8'd2;

	// Display mode code shown while the display machine has not started
	localparam logic [2:0] MODE_NONE = 3'd0;

	// Classify a temperature against the three thresholds
	function automatic band_t band_of(input logic [7:0] t, input cfg_t c);
		band_t b;
		b.slow = (c.slow_th <= t) && (t < c.med_th);
		b.med  = (c.med_th <= t) && (t < c.fast_th);
		b.fast = (c.fast_th <= t);
		return b;
	endfunction

endpackage

[src/mgfs_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick requests and results.
// Standalone; no package dependency.
interface mgfs_tick_if;
	logic       valid;
	logic       ready;
	logic       sensor_active;
	logic [9:0] adc_sample;

	modport source (output valid, output sensor_active, output adc_sample, input ready);
	modport sink (input valid, input sensor_active, input adc_sample, output ready);
endinterface

interface mgfs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] coil_pattern;
	logic       motion_flag;
	logic [2:0] display_mode;
	logic       display_updated;

	modport source (output valid, output coil_pattern, output motion_flag,
		output display_mode, output display_updated, input ready);
	modport sink (input valid, input coil_pattern, input motion_flag,
		input display_mode, input display_updated, output ready);
endinterface

[src/mgfs_display.sv]
`timescale 1ns / 1ps
// Display mode machine with its period timer.
// Depends on mgfs_pkg for cfg_t and the band decode.
module mgfs_display (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        temp,
	input  logic              motion_prev,
	input  mgfs_pkg::cfg_t    cfg,
	input  logic              period_load,
	input  logic [7:0]        period_value,
	output logic [2:0]        mode_next,
	output logic              updated_next
);
	import mgfs_pkg::*;

	typedef enum logic [2:0] {
		DISP_INIT      = 3'd0,
		DISP_OFF       = 3'd1,
		DISP_MOTION    = 3'd2,
		DISP_LOW       = 3'd3,
		DISP_MEDIUM    = 3'd4,
		DISP_FAST      = 3'd5,
		DISP_UNSTARTED = 3'd7
	} disp_t;

	disp_t      disp_q, disp_n, disp_step;
	logic [7:0] timer_q;
	band_t      b;
	logic       fire;

	assign b = band_of(temp, cfg);
	assign fire = (timer_q == cfg.period);

	// Next mode when the machine steps; later checks override earlier ones
	always_comb begin
		disp_step = disp_q;
		case (disp_q)
			DISP_INIT: disp_step = DISP_OFF;
			DISP_OFF: disp_step = motion_prev ? DISP_MOTION : DISP_OFF;
			DISP_MOTION: begin
				if (b.slow) disp_step = DISP_LOW;
				if (b.med) disp_step = DISP_MEDIUM;
				if (b.fast) disp_step = DISP_FAST;
			end
			DISP_LOW: begin
				if (temp < cfg.slow_th) disp_step = DISP_OFF;
				if (b.med) disp_step = DISP_MEDIUM;
				if (b.slow) disp_step = DISP_LOW;
				if (!motion_prev) disp_step = DISP_OFF;
			end
			DISP_MEDIUM: begin
				if (temp < cfg.med_th) disp_step = DISP_LOW;
				if (b.fast) disp_step = DISP_FAST;
				if (b.med) disp_step = DISP_MEDIUM;
				if (!motion_prev) disp_step = DISP_OFF;
			end
			DISP_FAST: begin
				if (b.med) disp_step = DISP_MEDIUM;
				if (b.fast) disp_step = DISP_FAST;
				if (!motion_prev) disp_step = DISP_OFF;
			end
			default: disp_step = DISP_INIT;
		endcase
	end

	assign disp_n = fire ? disp_step : disp_q;
	assign mode_next = (disp_n > DISP_FAST) ? MODE_NONE : disp_n;
	assign updated_next = fire;

	// Hold state and timer; reload the timer on a period write before start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q <= DISP_UNSTARTED;
			timer_q <= RST_PERIOD;
		end else if (advance) begin
			disp_q <= disp_n;
			timer_q <= fire ? 8'd1 : timer_q + 8'd1;
		end else if (period_load && (disp_q > DISP_FAST)) begin
			timer_q <= period_value;
		end
	end

endmodule

[src/mgfs_motion.sv]
`timescale 1ns / 1ps
// Motion hold machine: sets the flag on detection and holds it for the
// configured number of ticks. Depends on mgfs_pkg for cfg_t.
module mgfs_motion (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           sensor,
	input  mgfs_pkg::cfg_t cfg,
	output logic           held_prev,
	output logic           held_next
);
	import mgfs_pkg::*;

	typedef enum logic [1:0] {
		MOT_UNSTARTED = 2'd0,
		MOT_INIT      = 2'd1,
		MOT_CHECK     = 2'd2,
		MOT_WAIT      = 2'd3
	} mot_t;

	mot_t        phase_q, phase_n;
	logic [15:0] hold_q, hold_n;
	logic        held_q;

	// Step the machine; re-arm the hold while the sensor stays active
	always_comb begin
		phase_n = phase_q;
		hold_n = hold_q;
		held_next = held_q;
		case (phase_q)
			MOT_INIT: begin
				phase_n = MOT_CHECK;
				held_next = 1'b0;
			end
			MOT_CHECK: begin
				if (sensor) begin
					phase_n = MOT_WAIT;
					hold_n = '0;
					held_next = 1'b1;
				end
			end
			MOT_WAIT: begin
				if (hold_q != 16'hFFFF) hold_n = hold_q + 16'd1;
				if ((hold_n >= cfg.hold_ticks) && !sensor) begin
					phase_n = MOT_CHECK;
					held_next = 1'b0;
				end
			end
			default: phase_n = MOT_INIT;
		endcase
		if ((phase_n == MOT_WAIT) && (hold_n >= cfg.hold_ticks) && sensor) hold_n = '0;
	end

	assign held_prev = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MOT_UNSTARTED;
			hold_q <= '0;
			held_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_n;
			hold_q <= hold_n;
			held_q <= held_next;
		end
	end

endmodule

[src/mgfs_stepper.sv]
`timescale 1ns / 1ps
// Four-phase one-hot stepper with band-selected step wait.
// Depends on mgfs_pkg for cfg_t and the band decode.
module mgfs_stepper (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic [7:0]     temp,
	input  logic           held,
	input  mgfs_pkg::cfg_t cfg,
	output logic [7:0]     coil_next
);
	import mgfs_pkg::*;

	typedef enum logic [2:0] {
		STEP_UNSTARTED = 3'd0,
		STEP_INIT      = 3'd1,
		STEP_P1        = 3'd2,
		STEP_P2        = 3'd3,
		STEP_P3        = 3'd4,
		STEP_P4        = 3'd5
	} step_t;

	step_t      phase_q, phase_n;
	logic [7:0] count_q, count_n;
	logic [7:0] wait_q, wait_n;
	band_t      b;

	assign b = band_of(temp, cfg);

	// Pick the wait by band, then advance one coil once the wait is reached while motion is held
	always_comb begin
		wait_n = wait_q;
		if (b.slow) wait_n = cfg.wait_slow;
		if (b.med) wait_n = cfg.wait_med;
		if (b.fast) wait_n = cfg.wait_fast;

		phase_n = phase_q;
		count_n = count_q;
		case (phase_q)
			STEP_INIT: phase_n = STEP_P1;
			STEP_P1, STEP_P2, STEP_P3, STEP_P4: begin
				if ((count_q >= wait_n) && held) begin
					count_n = '0;
					case (phase_q)
						STEP_P1: phase_n = STEP_P2;
						STEP_P2: phase_n = STEP_P3;
						STEP_P3: phase_n = STEP_P4;
						default: phase_n = STEP_P1;
					endcase
				end
			end
			default: phase_n = STEP_INIT;
		endcase
		if ((phase_n >= STEP_P1) && (phase_n <= STEP_P4)) count_n = count_n + 8'd1;
	end

	// Drive byte for the new phase
	always_comb begin
		case (phase_n)
			STEP_P1: coil_next = 8'h80;
			STEP_P2: coil_next = 8'h40;
			STEP_P3: coil_next = 8'h20;
			STEP_P4: coil_next = 8'h10;
			default: coil_next = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= STEP_UNSTARTED;
			count_q <= '0;
			wait_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			count_q <= count_n;
			wait_q <= wait_n;
		end
	end

endmodule

[src/motion_gated_fan_stepper_controller_core.sv]
`timescale 1ns / 1ps
// Motion-gated fan stepper controller, top level.
// Depends on mgfs_pkg, mgfs_if and the display, motion and stepper modules.
//
// Usage: each request on the ticks channel is one scheduler tick carrying
// the motion sensor bit and an ADC sample (low eight bits = temperature).
// Every tick yields exactly one request on the results channel: coil drive
// byte, held motion flag, display mode code and a display-stepped flag.
// A tick passes through the input register, then the tick logic feeding the
// result register, which drives the results channel. Throughput is one tick
// per cycle while the receiver does not stall; the three state machines
// update together in one pass.
// When the receiver stalls, the result register holds; one more tick may
// wait in the input register, after which ticks.ready drops.
// Reset (arst_n low) clears both stages, returns all machines to their
// unstarted phases and loads the register defaults. The configuration
// port writes one register per cycle with cfg_wen high; write it only
// while no tick is in flight.
module motion_gated_fan_stepper_controller_core (
	input  logic                            clk,
	input  logic                            arst_n,
	mgfs_tick_if.sink                       ticks,
	mgfs_result_if.source                   results,
	input  logic                            cfg_wen,
	input  logic [mgfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mgfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mgfs_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       sensor_s1;
	logic [7:0] temp_s1;
	logic       valid_s2;
	logic [7:0] coil_s2;
	logic       motion_s2;
	logic [2:0] mode_s2;
	logic       updated_s2;
	logic       out_free;
	logic       advance;
	logic       held_prev, held_next;
	logic [2:0] mode_next;
	logic       updated_next;
	logic [7:0] coil_next;
	logic       period_load;

	assign out_free = !valid_s2 || results.ready;
	assign advance = valid_s1 && out_free;
	assign ticks.ready = !valid_s1 || advance;
	assign period_load = cfg_wen && (cfg_index == REG_PERIOD);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow_th <= RST_SLOW_TH;
			cfg_q.med_th <= RST_MED_TH;
			cfg_q.fast_th <= RST_FAST_TH;
			cfg_q.hold_ticks <= RST_HOLD_TICKS;
			cfg_q.period <= RST_PERIOD;
			cfg_q.wait_slow <= RST_WAIT_SLOW;
			cfg_q.wait_med <= RST_WAIT_MED;
			cfg_q.wait_fast <= RST_WAIT_FAST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SLOW_TH: cfg_q.slow_th <= cfg_wdata[7:0];
				REG_MED_TH: cfg_q.med_th <= cfg_wdata[7:0];
				REG_FAST_TH: cfg_q.fast_th <= cfg_wdata[7:0];
				REG_HOLD_TICKS: cfg_q.hold_ticks <= cfg_wdata;
				REG_PERIOD: cfg_q.period <= cfg_wdata[7:0];
				REG_WAIT_SLOW: cfg_q.wait_slow <= cfg_wdata[7:0];
				REG_WAIT_MED: cfg_q.wait_med <= cfg_wdata[7:0];
				REG_WAIT_FAST: cfg_q.wait_fast <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// Input stage: take a tick whenever the stage is empty or empties this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ticks.ready) begin
			valid_s1 <= ticks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			sensor_s1 <= ticks.sensor_active;
			temp_s1 <= ticks.adc_sample[7:0];
		end
	end

	mgfs_display u_display (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.temp         (temp_s1),
		.motion_prev  (held_prev),
		.cfg          (cfg_q),
		.period_load  (period_load),
		.period_value (cfg_wdata[7:0]),
		.mode_next    (mode_next),
		.updated_next (updated_next)
	);

	mgfs_motion u_motion (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.sensor    (sensor_s1),
		.cfg       (cfg_q),
		.held_prev (held_prev),
		.held_next (held_next)
	);

	mgfs_stepper u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.temp      (temp_s1),
		.held      (held_next),
		.cfg       (cfg_q),
		.coil_next (coil_next)
	);

	// Result stage: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coil_s2 <= coil_next;
			motion_s2 <= held_next;
			mode_s2 <= mode_next;
			updated_s2 <= updated_next;
		end
	end

	assign results.valid = valid_s2;
	assign results.coil_pattern = coil_s2;
	assign results.motion_flag = motion_s2;
	assign results.display_mode = mode_s2;
	assign results.display_updated = updated_s2;

`ifndef SYNTH
	// A tick that moved into the result stage shows up as a valid result
	a_advance_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> results.valid)
		else $error("advanced tick did not reach the result register");

	// Both stages full and the receiver stalled: no new request is taken
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !results.ready) |-> !ticks.ready)
		else $error("tick accepted while both stages are full");

	// At most one coil driven at a time
	a_coil_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> $onehot0(results.coil_pattern))
		else $error("more than one stepper coil driven");

	// Display mode codes stay within the defined set
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.display_mode <= 3'd5))
		else $error("display mode code out of range");
`endif

endmodule

[dv/mgfs_tick_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the motion-gated fan stepper controller: watches the tick,
// result and register-write ports, predicts each result and compares in order.
// Depends on mgfs_pkg and the channel interfaces in mgfs_if.
module mgfs_tick_scoreboard (
	input  logic                            clk,
	input  logic                            arst_n,
	mgfs_tick_if                            ticks,
	mgfs_result_if                          results,
	input  logic                            cfg_wen,
	input  logic [mgfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mgfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int REPORT_LIMIT = 10;

	// Motion hold phases
	localparam logic [1:0] MOT_UNSTARTED = 2'd0;
	localparam logic [1:0] MOT_INIT      = 2'd1;
	localparam logic [1:0] MOT_CHECK     = 2'd2;
	localparam logic [1:0] MOT_WAIT      = 2'd3;

	// Display mode phases; the low six are also the output codes
	localparam logic [2:0] DISP_INIT      = 3'd0;
	localparam logic [2:0] DISP_OFF       = 3'd1;
	localparam logic [2:0] DISP_MOTION    = 3'd2;
	localparam logic [2:0] DISP_LOW       = 3'd3;
	localparam logic [2:0] DISP_MEDIUM    = 3'd4;
	localparam logic [2:0] DISP_FAST      = 3'd5;
	localparam logic [2:0] DISP_SPARE     = 3'd6;
	localparam logic [2:0] DISP_UNSTARTED = 3'd7;

	// Stepper phases
	localparam logic [2:0] STEP_UNSTARTED = 3'd0;
	localparam logic [2:0] STEP_INIT      = 3'd1;
	localparam logic [2:0] STEP_PULSE1    = 3'd2;
	localparam logic [2:0] STEP_PULSE4    = 3'd5;

	typedef struct packed {
		logic [7:0] coil;
		logic       motion;
		logic [2:0] mode;
		logic       updated;
	} tick_result_t;

	mgfs_pkg::cfg_t cfg;
	logic [1:0]     mot_state;
	logic [15:0]    hold_cnt;
	logic           held;
	logic [2:0]     disp_state;
	logic [7:0]     disp_timer;
	logic [2:0]     step_state;
	logic [7:0]     step_cnt;
	logic [7:0]     step_wait;

	tick_result_t pending_results[$];

	// Advance the controller state by one tick and return its result
	function automatic tick_result_t tick_outcome(input logic sensor, input logic [9:0] adc);
		logic [7:0]   t;
		logic         in_slow;
		logic         in_med;
		logic         in_fast;
		logic [2:0]   s;
		tick_result_t r;

		t = adc[7:0];
		in_slow = (cfg.slow_th <= t) && (t < cfg.med_th);
		in_med = (cfg.med_th <= t) && (t < cfg.fast_th);
		in_fast = cfg.fast_th <= t;
		r = '0;

		// Step the display on the period boundary, with the motion flag from before this tick
		if (disp_timer == cfg.period) begin
			s = disp_state;
			case (disp_state)
				DISP_INIT: s = DISP_OFF;
				DISP_OFF: s = held ? DISP_MOTION : DISP_OFF;
				DISP_MOTION: begin
					if (in_slow) s = DISP_LOW;
					if (in_med) s = DISP_MEDIUM;
					if (in_fast) s = DISP_FAST;
				end
				DISP_LOW: begin
					if (t < cfg.slow_th) s = DISP_OFF;
					if (in_med) s = DISP_MEDIUM;
					if (in_slow) s = DISP_LOW;
					if (!held) s = DISP_OFF;
				end
				DISP_MEDIUM: begin
					if (t < cfg.med_th) s = DISP_LOW;
					if (in_fast) s = DISP_FAST;
					if (in_med) s = DISP_MEDIUM;
					if (!held) s = DISP_OFF;
				end
				DISP_FAST: begin
					if (in_med) s = DISP_MEDIUM;
					if (in_fast) s = DISP_FAST;
					if (!held) s = DISP_OFF;
				end
				default: s = DISP_INIT;
			endcase
			disp_state = s;
			disp_timer = 8'd0;
			r.updated = 1'b1;
		end
		disp_timer = disp_timer + 8'd1;

		// Hold the motion flag, re-arming while the sensor stays active
		case (mot_state)
			MOT_INIT: begin
				mot_state = MOT_CHECK;
				held = 1'b0;
			end
			MOT_CHECK: if (sensor) begin
				mot_state = MOT_WAIT;
				hold_cnt = 16'd0;
				held = 1'b1;
			end
			MOT_WAIT: begin
				if (hold_cnt != 16'hFFFF) hold_cnt = hold_cnt + 16'd1;
				if (hold_cnt >= cfg.hold_ticks && !sensor) begin
					mot_state = MOT_CHECK;
					held = 1'b0;
				end
			end
			default: mot_state = MOT_INIT;
		endcase
		if (mot_state == MOT_WAIT && hold_cnt >= cfg.hold_ticks && sensor) hold_cnt = 16'd0;

		// Pick the step wait by band; below every band keep the last one
		if (in_slow) step_wait = cfg.wait_slow;
		if (in_med) step_wait = cfg.wait_med;
		if (in_fast) step_wait = cfg.wait_fast;

		// Advance one coil once the wait is reached, only while motion is held
		if (step_state == STEP_INIT) begin
			step_state = STEP_PULSE1;
		end else if (step_state >= STEP_PULSE1 && step_state <= STEP_PULSE4) begin
			if (step_cnt >= step_wait && held) begin
				step_state = (step_state == STEP_PULSE4) ? STEP_PULSE1 : step_state + 3'd1;
				step_cnt = 8'd0;
			end
		end else begin
			step_state = STEP_INIT;
		end
		if (step_state >= STEP_PULSE1 && step_state <= STEP_PULSE4) begin
			step_cnt = step_cnt + 8'd1;
			r.coil = 8'h80 >> (step_state - STEP_PULSE1);
		end

		r.motion = held;
		r.mode = (disp_state <= DISP_FAST) ? disp_state : mgfs_pkg::MODE_NONE;
		return r;
	endfunction

	// Track register writes, predict accepted ticks, check accepted results
	always @(posedge clk or negedge arst_n) begin
		tick_result_t exp_r;
		tick_result_t got_r;

		if (!arst_n) begin
			cfg.slow_th = mgfs_pkg::RST_SLOW_TH;
			cfg.med_th = mgfs_pkg::RST_MED_TH;
			cfg.fast_th = mgfs_pkg::RST_FAST_TH;
			cfg.hold_ticks = mgfs_pkg::RST_HOLD_TICKS;
			cfg.period = mgfs_pkg::RST_PERIOD;
			cfg.wait_slow = mgfs_pkg::RST_WAIT_SLOW;
			cfg.wait_med = mgfs_pkg::RST_WAIT_MED;
			cfg.wait_fast = mgfs_pkg::RST_WAIT_FAST;
			mot_state = MOT_UNSTARTED;
			hold_cnt = 16'd0;
			held = 1'b0;
			disp_state = DISP_UNSTARTED;
			disp_timer = mgfs_pkg::RST_PERIOD;
			step_state = STEP_UNSTARTED;
			step_cnt = 8'd0;
			step_wait = 8'd0;
			pending_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					mgfs_pkg::REG_SLOW_TH: cfg.slow_th = cfg_wdata[7:0];
					mgfs_pkg::REG_MED_TH: cfg.med_th = cfg_wdata[7:0];
					mgfs_pkg::REG_FAST_TH: cfg.fast_th = cfg_wdata[7:0];
					mgfs_pkg::REG_HOLD_TICKS: cfg.hold_ticks = cfg_wdata;
					mgfs_pkg::REG_PERIOD: begin
						cfg.period = cfg_wdata[7:0];
						// A display that has not started reloads its timer
						if (disp_state == DISP_UNSTARTED || disp_state == DISP_SPARE)
							disp_timer = cfg_wdata[7:0];
					end
					mgfs_pkg::REG_WAIT_SLOW: cfg.wait_slow = cfg_wdata[7:0];
					mgfs_pkg::REG_WAIT_MED: cfg.wait_med = cfg_wdata[7:0];
					mgfs_pkg::REG_WAIT_FAST: cfg.wait_fast = cfg_wdata[7:0];
					default: ;
				endcase
			end

			if (ticks.valid && ticks.ready)
				pending_results.push_back(tick_outcome(ticks.sensor_active, ticks.adc_sample));

			if (results.valid && results.ready) begin
				got_r.coil = results.coil_pattern;
				got_r.motion = results.motion_flag;
				got_r.mode = results.display_mode;
				got_r.updated = results.display_updated;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: ERROR result request with no tick pending: %h", $realtime,
							got_r);
				end else begin
					exp_r = pending_results.pop_front();
					if (got_r.coil !== exp_r.coil || got_r.motion !== exp_r.motion ||
						got_r.mode !== exp_r.mode || got_r.updated !== exp_r.updated) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: ERROR exp/got coil %h/%h motion %b/%b mode %0d/%0d upd %b/%b",
								$realtime,
								exp_r.coil, got_r.coil, exp_r.motion, got_r.motion,
								exp_r.mode, got_r.mode, exp_r.updated, got_r.updated);
					end
				end
			end
		end
		outstanding = pending_results.size();
	end

endmodule

[dv/motion_gated_fan_stepper_controller_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the motion-gated fan stepper controller: clock, reset,
// register setup, tick requests and result back-pressure, and the verdict.
// Depends on mgfs_pkg, mgfs_if, the controller core and mgfs_tick_scoreboard.
module motion_gated_fan_stepper_controller_core_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_TICKS = 103;
	localparam int DIR_COUNT = 24;

	// Directed ticks, first request in the top bits
	localparam logic [DIR_COUNT-1:0] DIR_SENSOR = 24'b0111_1111_1111_0000_1000_0110;
	localparam logic [DIR_COUNT*10-1:0] DIR_ADC = {
		10'd0, 10'd1023, 10'd140, 10'd139, 10'd140, 10'd169, 10'd170, 10'd175,
		10'd176, 10'd255, 10'd432, 10'd682, 10'd908, 10'd175, 10'd176, 10'd0,
		10'd1023, 10'd169, 10'd170, 10'd139, 10'd255, 10'd140, 10'd176, 10'd0};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wen;
	logic [mgfs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mgfs_pkg::CFG_DATA_W-1:0] cfg_wdata;
	int                              mismatches;
	int                              outstanding;
	int                              cycles = 0;
	int                              idle_pct;
	int                              stall_pct;
	logic                            motion_on;
	mgfs_pkg::cfg_t                  cur_cfg;

	mgfs_tick_if   ticks ();
	mgfs_result_if results ();

	motion_gated_fan_stepper_controller_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.ticks     (ticks),
		.results   (results),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	mgfs_tick_scoreboard scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.ticks       (ticks),
		.results     (results),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drop the run if it stalls
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Stall the result channel at the phase's rate
	always @(posedge clk) begin
		results.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Write one register; call at a rising edge
	task automatic write_reg(input logic [mgfs_pkg::CFG_IDX_W-1:0] idx,
		input logic [mgfs_pkg::CFG_DATA_W-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Load every register, then release the write port
	task automatic configure(input mgfs_pkg::cfg_t c);
		write_reg(mgfs_pkg::REG_SLOW_TH, {8'd0, c.slow_th});
		write_reg(mgfs_pkg::REG_MED_TH, {8'd0, c.med_th});
		write_reg(mgfs_pkg::REG_FAST_TH, {8'd0, c.fast_th});
		write_reg(mgfs_pkg::REG_HOLD_TICKS, c.hold_ticks);
		write_reg(mgfs_pkg::REG_PERIOD, {8'd0, c.period});
		write_reg(mgfs_pkg::REG_WAIT_SLOW, {8'd0, c.wait_slow});
		write_reg(mgfs_pkg::REG_WAIT_MED, {8'd0, c.wait_med});
		write_reg(mgfs_pkg::REG_WAIT_FAST, {8'd0, c.wait_fast});
		cfg_wen <= 1'b0;
		cur_cfg = c;
	endtask

	// Offer one tick request and hold it until accepted
	task automatic send_tick(input logic sensor, input logic [9:0] adc);
		logic took;
		while ($urandom_range(99) < idle_pct) begin
			ticks.valid <= 1'b0;
			@(posedge clk);
		end
		ticks.valid <= 1'b1;
		ticks.sensor_active <= sensor;
		ticks.adc_sample <= adc;
		do begin
			@(negedge clk);
			took = ticks.ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain;
		ticks.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (2) @(posedge clk);
	endtask

	// Temperature near a threshold most of the time, random upper bits
	function automatic logic [9:0] pick_sample(input mgfs_pkg::cfg_t c);
		logic [7:0] base;
		logic [7:0] offs;
		logic [1:0] upper;
		case ($urandom_range(4))
			0: base = c.slow_th;
			1: base = c.med_th;
			2: base = c.fast_th;
			default: base = 8'($urandom_range(255));
		endcase
		offs = 8'($urandom_range(4));
		upper = 2'($urandom_range(3));
		return {upper, base + offs - 8'd2};
	endfunction

	// Mostly ordered bands with short holds, periods and waits
	function automatic mgfs_pkg::cfg_t random_cfg();
		mgfs_pkg::cfg_t c;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] d;
		a = 8'($urandom_range(255));
		b = 8'($urandom_range(255));
		d = 8'($urandom_range(255));
		if ($urandom_range(4) != 0) begin
			if (a > b) {a, b} = {b, a};
			if (b > d) {b, d} = {d, b};
			if (a > b) {a, b} = {b, a};
		end
		c.slow_th = a;
		c.med_th = b;
		c.fast_th = d;
		c.hold_ticks = ($urandom_range(7) == 0) ? 16'($urandom_range(65535, 1)) :
			16'($urandom_range(24, 1));
		c.period = ($urandom_range(5) == 0) ? 8'($urandom_range(255, 1)) :
			8'($urandom_range(12, 1));
		c.wait_slow = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
			8'($urandom_range(6));
		c.wait_med = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
			8'($urandom_range(6));
		c.wait_fast = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
			8'($urandom_range(6));
		return c;
	endfunction

	initial begin
		mgfs_pkg::cfg_t c;
		logic sensor;

		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		ticks.valid <= 1'b0;
		ticks.sensor_active <= 1'b0;
		ticks.adc_sample <= '0;
		idle_pct = 0;
		stall_pct = 0;
		motion_on = 1'b0;
		cur_cfg = {mgfs_pkg::RST_SLOW_TH, mgfs_pkg::RST_MED_TH, mgfs_pkg::RST_FAST_TH,
			mgfs_pkg::RST_HOLD_TICKS, mgfs_pkg::RST_PERIOD, mgfs_pkg::RST_WAIT_SLOW,
			mgfs_pkg::RST_WAIT_MED, mgfs_pkg::RST_WAIT_FAST};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: default thresholds and waits, period set before the first tick
		write_reg(mgfs_pkg::REG_PERIOD, 16'd1);
		write_reg(mgfs_pkg::REG_HOLD_TICKS, 16'd3);
		cfg_wen <= 1'b0;
		cur_cfg.period = 8'd1;
		cur_cfg.hold_ticks = 16'd3;
		for (int i = 0; i < DIR_COUNT; i++)
			send_tick(DIR_SENSOR[DIR_COUNT-1-i], DIR_ADC[(DIR_COUNT-1-i)*10 +: 10]);
		drain();

		// Random phases: low extremes, high extremes, then random settings
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: c = {8'd0, 8'd0, 8'd0, 16'd1, 8'd1, 8'd0, 8'd0, 8'd0};
				1: c = {8'd255, 8'd255, 8'd255, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255};
				default: c = random_cfg();
			endcase
			configure(c);
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 74;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 74;
				end
				default: begin
					idle_pct = 15;
					stall_pct = 15;
				end
			endcase
			// Motion arrives in bursts with some sensor noise
			repeat (PHASE_TICKS) begin
				if ($urandom_range(7) == 0) motion_on = !motion_on;
				sensor = ($urandom_range(9) == 0) ? !motion_on : motion_on;
				send_tick(sensor, pick_sample(cur_cfg));
			end
			drain();
		end

		stall_pct = 0;
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
